### hdl/two_level_priority_task_deque_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level priority task deque
// Clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PRIORITY_TASK_DEQUE_MACROS_SVH
`define TWO_LEVEL_PRIORITY_TASK_DEQUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tlpd_pkg.sv
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared types and constants of the two-level priority task deque.
// ----------------------------------------------------------------------------
package tlpd_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int HANDLE_W   = 32;
    localparam int REF_W      = 32;
    localparam int LEVEL_W    = 2;
    localparam int TDATA_BITS = 72;

    localparam logic [LEVEL_W-1:0] HIGH_CODE_RESET = 2'd1;

    typedef enum logic {
        KIND_PUT = 1'b0,
        KIND_GET = 1'b1
    } t_kind;

    // One operation broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop;
    } t_chain_ctrl;

    typedef struct packed {
        logic               ok;
        logic [HANDLE_W-1:0] handle;
        logic [REF_W-1:0]    data_ref;
        logic [LEVEL_W-1:0]  level;
    } t_result;

endpackage

### hdl/tlpd_cell.sv
// ----------------------------------------------------------------------------
// tlpd_cell
// One deque slot: holds an entry and an occupied bit, and moves them to or
// from its neighbors when the front is pushed or popped, or takes the new word on a push to the back.
// ----------------------------------------------------------------------------
module tlpd_cell
    import tlpd_pkg::*;
#(
    parameter int SB = HANDLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_chain_ctrl        i_ctrl,
    input  logic [SB-1:0]      i_new_handle,
    input  logic [REF_W-1:0]   i_new_ref,
    input  logic [LEVEL_W-1:0] i_new_level,
    input  logic               i_prev_occ,
    input  logic [SB-1:0]      i_prev_handle,
    input  logic [REF_W-1:0]   i_prev_ref,
    input  logic [LEVEL_W-1:0] i_prev_level,
    input  logic               i_next_occ,
    input  logic [SB-1:0]      i_next_handle,
    input  logic [REF_W-1:0]   i_next_ref,
    input  logic [LEVEL_W-1:0] i_next_level,
    output logic               o_occ,
    output logic [SB-1:0]      o_handle,
    output logic [REF_W-1:0]   o_ref,
    output logic [LEVEL_W-1:0] o_level
);

    logic               r_occ, n_occ;
    logic [SB-1:0]      r_handle, n_handle;
    logic [REF_W-1:0]   r_ref, n_ref;
    logic [LEVEL_W-1:0] r_level, n_level;

    always_comb begin
        n_occ    = r_occ;
        n_handle = r_handle;
        n_ref    = r_ref;
        n_level  = r_level;
        if (i_ctrl.pop) begin
            n_occ    = i_next_occ;
            n_handle = i_next_handle;
            n_ref    = i_next_ref;
            n_level  = i_next_level;
        end else if (i_ctrl.push_front) begin
            n_occ    = i_prev_occ;
            n_handle = i_prev_handle;
            n_ref    = i_prev_ref;
            n_level  = i_prev_level;
        end else if (i_ctrl.push_back && i_prev_occ && !r_occ) begin
            // The first free slot behind the occupied run takes the new word.
            n_occ    = 1'b1;
            n_handle = i_new_handle;
            n_ref    = i_new_ref;
            n_level  = i_new_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_ref    <= n_ref;
        r_level  <= n_level;
    end

    assign o_occ    = r_occ;
    assign o_handle = r_handle;
    assign o_ref    = r_ref;
    assign o_level  = r_level;

endmodule

### hdl/tlpd_out_reg.sv
// ----------------------------------------------------------------------------
// tlpd_out_reg
// Result register of the master stream; holds a word while the sink stalls.
// ----------------------------------------------------------------------------
module tlpd_out_reg
    import tlpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_result               i_result,
    output logic                  o_can_load,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: handle_out[31:0], data_ref_out[63:32],
    // level_out[65:64], zero fill.
    output logic [TDATA_BITS-1:0] m_axis_tdata,
    // Fields from bit 0: ok.
    output logic                  m_axis_tuser
);

    localparam int PAD_W = TDATA_BITS - HANDLE_W - REF_W - LEVEL_W;

    logic    r_valid, n_valid;
    t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (m_axis_tready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_can_load    = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_result.level, r_result.data_ref,
                            r_result.handle};
    assign m_axis_tuser  = r_result.ok;

endmodule

### hdl/two_level_priority_task_deque.sv
// ----------------------------------------------------------------------------
// Two-level priority task deque
// Bounded task queue kept in a chain of cells, front entry in cell zero.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per word: tuser is the kind
//   (put or get), tdata holds handle, data reference and priority. A put
//   whose priority equals the high code register goes in at the front,
//   any other put at the back; a get removes the front entry.
//   Every accepted word yields exactly one result word on the master
//   stream: tuser is ok, tdata the removed task (zero for a put or a miss).
//   The chain updates at the accepting edge and the result is registered.
//   Throughput is one word per cycle while the sink keeps up, set by the
//   cell chain shift and the one-word output register. When the sink
//   stalls, the output register holds its word and s_axis_tready drops
//   until the word is taken. Reset (synchronous, active low) empties the
//   queue and sets the high code to 1. The user writes the code by
//   i_cfg_we and i_cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "two_level_priority_task_deque_macros.svh"

module two_level_priority_task_deque
    import tlpd_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LEVEL_W-1:0]    i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: handle_in[31:0], data_ref_in[63:32],
    // level_in[65:64], zero fill.
    input  logic [TDATA_BITS-1:0] s_axis_tdata,
    // Fields from bit 0: kind.
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: handle_out[31:0], data_ref_out[63:32],
    // level_out[65:64], zero fill.
    output logic [TDATA_BITS-1:0] m_axis_tdata,
    // Fields from bit 0: ok.
    output logic                  m_axis_tuser
);

    localparam int SB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    logic [LEVEL_W-1:0] r_high_code;

    logic               w_accept;
    logic               w_can_load;
    t_kind              w_kind;
    logic [HANDLE_W-1:0] w_in_handle;
    logic [REF_W-1:0]   w_in_ref;
    logic [LEVEL_W-1:0] w_in_level;
    logic               w_full;
    logic               w_empty;
    t_chain_ctrl        w_ctrl;
    t_result            w_result;

    logic [DEPTH-1:0]   w_occ;
    logic [SB-1:0]      w_handle [DEPTH];
    logic [REF_W-1:0]   w_ref    [DEPTH];
    logic [LEVEL_W-1:0] w_level  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_code <= HIGH_CODE_RESET;
        end else if (i_cfg_we) begin
            r_high_code <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = w_can_load;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_kind        = t_kind'(s_axis_tuser);
    assign w_in_handle   = s_axis_tdata[HANDLE_W-1:0];
    assign w_in_ref      = s_axis_tdata[HANDLE_W+REF_W-1:HANDLE_W];
    assign w_in_level    = s_axis_tdata[HANDLE_W+REF_W+LEVEL_W-1:HANDLE_W+REF_W];
    assign w_full        = w_occ[DEPTH-1];
    assign w_empty       = !w_occ[0];

    always_comb begin
        w_ctrl   = '0;
        w_result = '0;
        unique case (w_kind)
            KIND_PUT: begin
                if (w_accept && !w_full) begin
                    w_ctrl.push_front = (w_in_level == r_high_code);
                    w_ctrl.push_back  = (w_in_level != r_high_code);
                end
                w_result.ok = !w_full;
            end
            KIND_GET: begin
                w_ctrl.pop = w_accept && !w_empty;
                if (!w_empty) begin
                    w_result.ok       = 1'b1;
                    w_result.handle   = HANDLE_W'(w_handle[0]);
                    w_result.data_ref = w_ref[0];
                    w_result.level    = w_level[0];
                end
            end
            default: begin
                w_ctrl   = '0;
                w_result = '0;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic               w_prev_occ;
        logic [SB-1:0]      w_prev_handle;
        logic [REF_W-1:0]   w_prev_ref;
        logic [LEVEL_W-1:0] w_prev_level;
        logic               w_next_occ;
        logic [SB-1:0]      w_next_handle;
        logic [REF_W-1:0]   w_next_ref;
        logic [LEVEL_W-1:0] w_next_level;

        // Cell zero sees the incoming word as an always-occupied left neighbor.
        if (i == 0) begin : g_head
            assign w_prev_occ    = 1'b1;
            assign w_prev_handle = w_in_handle[SB-1:0];
            assign w_prev_ref    = w_in_ref;
            assign w_prev_level  = w_in_level;
        end else begin : g_body
            assign w_prev_occ    = w_occ[i-1];
            assign w_prev_handle = w_handle[i-1];
            assign w_prev_ref    = w_ref[i-1];
            assign w_prev_level  = w_level[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_next_occ    = 1'b0;
            assign w_next_handle = '0;
            assign w_next_ref    = '0;
            assign w_next_level  = '0;
        end else begin : g_link
            assign w_next_occ    = w_occ[i+1];
            assign w_next_handle = w_handle[i+1];
            assign w_next_ref    = w_ref[i+1];
            assign w_next_level  = w_level[i+1];
        end

        tlpd_cell #(
            .SB(SB)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new_handle  (w_in_handle[SB-1:0]),
            .i_new_ref     (w_in_ref),
            .i_new_level   (w_in_level),
            .i_prev_occ    (w_prev_occ),
            .i_prev_handle (w_prev_handle),
            .i_prev_ref    (w_prev_ref),
            .i_prev_level  (w_prev_level),
            .i_next_occ    (w_next_occ),
            .i_next_handle (w_next_handle),
            .i_next_ref    (w_next_ref),
            .i_next_level  (w_next_level),
            .o_occ         (w_occ[i]),
            .o_handle      (w_handle[i]),
            .o_ref         (w_ref[i]),
            .o_level       (w_level[i])
        );
    end

    tlpd_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_result      (w_result),
        .o_can_load    (w_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Occupied cells always form one run starting at the front.
    `TLPD_ASSERT_NOW(a_occ_run, i_clk, i_rst_n, 1'b1, ((w_occ >> 1) & ~w_occ) == '0, "occupied cells not contiguous")
    // A put into a full queue is refused.
    `TLPD_ASSERT_NEXT(a_full_put, i_clk, i_rst_n, i_rst_n && w_accept && w_kind == KIND_PUT && w_full, !m_axis_tuser, "put on full queue reported ok")
    // A get on an empty queue returns no data.
    `TLPD_ASSERT_NEXT(a_empty_get, i_clk, i_rst_n, i_rst_n && w_accept && w_kind == KIND_GET && w_empty, m_axis_tdata == '0 && !m_axis_tuser, "get on empty queue returned data")
    // A stored put grows the queue by exactly one entry.
    `TLPD_ASSERT_NEXT(a_put_grow, i_clk, i_rst_n, i_rst_n && w_accept && w_kind == KIND_PUT && !w_full, $countones(w_occ) == $countones($past(w_occ)) + 1, "put did not add one entry")

endmodule

### test/tb_two_level_priority_task_deque.sv
// ----------------------------------------------------------------------------
// tb_two_level_priority_task_deque
// Self-checking bench: a short scripted sequence and then random put/get
// traffic in several phases, each with its own high code and idle pattern.
// Every result word is checked against the script's expected word or a shadow deque kept in the bench.
// ----------------------------------------------------------------------------
module tb_two_level_priority_task_deque;
    import tlpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 244;
    localparam int MAX_REPORTS    = 40;
    localparam int FILL_LSB       = HANDLE_W + REF_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0] PHASE_CODE [PHASES] = '{
        2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1
    };

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] handle;
        logic [REF_W-1:0]    data_ref;
        logic [LEVEL_W-1:0]  level;
        logic [7:0]          reps;
        logic                typed;
        t_result             want;
    } t_script_row;

    // Runs with the reset high code of 1. Repeated rows step the handle up
    // and the reference down so that every stored entry is distinct.
    localparam t_script_row SCRIPT [10] = '{
        // Get on an empty queue finds nothing.
        '{KIND_GET, 32'h0000_0000, 32'h0000_0000, 2'd0, 8'd1, 1'b1,
          '{1'b0, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        '{KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 2'd1, 8'd1, 1'b1,
          '{1'b1, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        '{KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 2'd0, 8'd1, 1'b1,
          '{1'b1, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        '{KIND_PUT, 32'h1234_5678, 32'h9ABC_DEF0, 2'd3, 8'd1, 1'b1,
          '{1'b1, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        '{KIND_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 2'd2, 8'd1, 1'b1,
          '{1'b1, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        // The high-priority put went in at the front, so it comes out first.
        '{KIND_GET, 32'h0000_0000, 32'h0000_0000, 2'd0, 8'd1, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 2'd1}},
        // Front pushes wrap the front pointer and fill the queue.
        '{KIND_PUT, 32'hA5A5_0000, 32'h5A5A_0000, 2'd1, 8'd13, 1'b0,
          '{1'b0, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        // Puts on a full queue are refused at either end.
        '{KIND_PUT, 32'hDEAD_BEEF, 32'hCAFE_F00D, 2'd0, 8'd1, 1'b1,
          '{1'b0, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        '{KIND_PUT, 32'h1357_9BDF, 32'h2468_ACE0, 2'd1, 8'd1, 1'b1,
          '{1'b0, 32'h0000_0000, 32'h0000_0000, 2'd0}},
        '{KIND_GET, 32'h0000_0000, 32'h0000_0000, 2'd0, 8'd3, 1'b0,
          '{1'b0, 32'h0000_0000, 32'h0000_0000, 2'd0}}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [LEVEL_W-1:0]    i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_BITS-1:0] s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [TDATA_BITS-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // Shadow copy of the deque and its high code.
    logic [HANDLE_W-1:0] shadow_handle [DEPTH_DEF];
    logic [REF_W-1:0]    shadow_ref    [DEPTH_DEF];
    logic [LEVEL_W-1:0]  shadow_level  [DEPTH_DEF];
    int unsigned         front_pos  = 0;
    int unsigned         fill_count = 0;
    logic [LEVEL_W-1:0]  high_code  = HIGH_CODE_RESET;

    t_result pending_results [$];
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;

    always #5 i_clk = ~i_clk;

    two_level_priority_task_deque #(
        .DEPTH       (DEPTH_DEF),
        .HANDLE_BITS (HANDLE_BITS_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Applies one operation to the shadow deque and returns its result word.
    function automatic t_result compute_deque_result(
        input t_kind               kind,
        input logic [HANDLE_W-1:0] handle,
        input logic [REF_W-1:0]    data_ref,
        input logic [LEVEL_W-1:0]  level
    );
        t_result     res;
        int unsigned slot;
        res = '0;
        if (kind == KIND_PUT) begin
            if (fill_count < DEPTH_DEF) begin
                if (level == high_code) begin
                    front_pos = (front_pos + DEPTH_DEF - 1) % DEPTH_DEF;
                    slot      = front_pos;
                end else begin
                    slot = (front_pos + fill_count) % DEPTH_DEF;
                end
                shadow_handle[slot] = handle;
                shadow_ref[slot]    = data_ref;
                shadow_level[slot]  = level;
                fill_count++;
                res.ok = 1'b1;
            end
        end else if (fill_count != 0) begin
            res = '{1'b1, shadow_handle[front_pos], shadow_ref[front_pos],
                    shadow_level[front_pos]};
            front_pos = (front_pos + 1) % DEPTH_DEF;
            fill_count--;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        return $urandom;
    endfunction

    // Offers one word, waits for it to be taken and records what it must give.
    task automatic send_word(
        input t_kind               kind,
        input logic [HANDLE_W-1:0] handle,
        input logic [REF_W-1:0]    data_ref,
        input logic [LEVEL_W-1:0]  level,
        input logic                typed,
        input t_result             want
    );
        t_result predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= TDATA_BITS'({level, data_ref, handle});
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = compute_deque_result(kind, handle, data_ref, level);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // The code is only changed once every result has drained.
    task automatic write_high_code(input logic [LEVEL_W-1:0] code);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        high_code = code;
    endtask

    task automatic compare_field(
        input string       field,
        input logic [31:0] want_v,
        input logic [31:0] got_v
    );
        if (want_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: word expected none actual ok=%b tdata=%h", $time,
                             m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                compare_field("ok", 32'(want.ok), 32'(m_axis_tuser));
                compare_field("handle", want.handle, m_axis_tdata[HANDLE_W-1:0]);
                compare_field("data_ref", want.data_ref,
                              m_axis_tdata[HANDLE_W+REF_W-1:HANDLE_W]);
                compare_field("level", 32'(want.level),
                              32'(m_axis_tdata[FILL_LSB-1:HANDLE_W+REF_W]));
                compare_field("fill", '0, 32'(m_axis_tdata[TDATA_BITS-1:FILL_LSB]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_kind kind;
        int    put_pct;
        put_pct = 50;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SCRIPT[k]) begin
            for (int n = 0; n < SCRIPT[k].reps; n++)
                send_word(SCRIPT[k].kind, SCRIPT[k].handle + n, SCRIPT[k].data_ref - n,
                          SCRIPT[k].level, SCRIPT[k].typed, SCRIPT[k].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_high_code(PHASE_CODE[p]);
            case (p % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 67;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 67;
                end
                default: begin
                    src_idle_pct   = 18;
                    sink_stall_pct = 18;
                end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // Bursts that lean toward puts or gets drive the queue to full
                // and back to empty several times per phase.
                if (i % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       put_pct = 85;
                        1:       put_pct = 15;
                        default: put_pct = 50;
                    endcase
                end
                kind = ($urandom_range(0, 99) < put_pct) ? KIND_PUT : KIND_GET;
                send_word(kind, pick_word(), pick_word(), LEVEL_W'($urandom_range(0, 3)),
                          1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
